@@ design/prq_pkg.sv @@
package prq_pkg;

  localparam int unsigned PRIORITY_LEVELS = 32;
  localparam int unsigned TASK_SLOTS      = 32;
  localparam int unsigned TASK_W          = 5;
  localparam int unsigned LEVEL_W         = 5;
  localparam int unsigned COUNT_W         = 6;

  typedef logic [TASK_W-1:0]          task_t;
  typedef logic [LEVEL_W-1:0]         level_t;
  typedef logic [COUNT_W-1:0]         count_t;
  typedef logic [PRIORITY_LEVELS-1:0] bitmap_t;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_ROTATE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ARG   = 2'd1,
    ST_BAD_STATE = 2'd2
  } status_e;

  // The action is kept as raw bits so the unused code reaches the decoder.
  typedef struct packed {
    logic [1:0] action;
    task_t      task_id;
    level_t     level;
  } op_t;

  typedef struct packed {
    status_e status;
    logic    highest_valid;
    task_t   highest_task;
    level_t  highest_priority;
    count_t  ready_count;
    bitmap_t ready_bitmap;
  } result_t;

  typedef struct packed {
    logic   found;
    level_t idx;
  } find_t;

  // Lowest set bit of the level bitmap, which is the highest priority level.
  function automatic find_t first_set(input bitmap_t vec);
    find_t res;
    res.found = 1'b0;
    res.idx   = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res.found = 1'b1;
        res.idx   = level_t'(i);
      end
    end
    return res;
  endfunction

endpackage

@@ design/prq_core.sv @@
module prq_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             exec_i,
  input  prq_pkg::op_t     op_i,
  output prq_pkg::result_t result_o
);
  import prq_pkg::*;

  // Control state, cleared by reset.
  logic [TASK_SLOTS-1:0] queued_q, queued_d;
  bitmap_t               bitmap_q, bitmap_d;
  count_t                total_q, total_d;

  // Link storage; every read is guarded by the queued bits or the bitmap.
  level_t task_level_q [TASK_SLOTS];
  task_t  next_q       [TASK_SLOTS];
  task_t  prev_q       [TASK_SLOTS];
  task_t  head_q       [PRIORITY_LEVELS];
  task_t  tail_q       [PRIORITY_LEVELS];

  find_t   top_cur, top_new;
  level_t  op_level;
  task_t   op_task, head_cur, tail_cur, next_t, prev_t, head_new;
  logic    is_head, is_tail, level_we;
  logic    head_we, tail_we, next_we, prev_we;
  task_t   head_wd, tail_wd, next_wa, next_wd, prev_wa, prev_wd;
  status_e status;

  // Rotate works on the head of the highest level; the other actions on the
  // requested task and level. One port per link array covers every action.
  always_comb begin
    top_cur  = first_set(bitmap_q);
    op_level = (op_i.action == ACT_ROTATE) ? top_cur.idx : op_i.level;
    head_cur = head_q[op_level];
    tail_cur = tail_q[op_level];
    op_task  = (op_i.action == ACT_ROTATE) ? head_cur : op_i.task_id;
    next_t   = next_q[op_task];
    prev_t   = prev_q[op_task];
    is_head  = (head_cur == op_task);
    is_tail  = (tail_cur == op_task);
  end

  always_comb begin
    status   = ST_OK;
    queued_d = queued_q;
    bitmap_d = bitmap_q;
    total_d  = total_q;
    level_we = 1'b0;
    head_we  = 1'b0;
    head_wd  = op_task;
    tail_we  = 1'b0;
    tail_wd  = op_task;
    next_we  = 1'b0;
    next_wa  = tail_cur;
    next_wd  = op_task;
    prev_we  = 1'b0;
    prev_wa  = op_task;
    prev_wd  = tail_cur;
    unique case (op_i.action)
      ACT_INSERT: begin
        if (queued_q[op_task]) begin
          status = ST_BAD_STATE;
        end else begin
          if (!bitmap_q[op_level]) begin
            head_we = 1'b1;
          end else begin
            next_we = 1'b1;
            prev_we = 1'b1;
          end
          tail_we            = 1'b1;
          bitmap_d[op_level] = 1'b1;
          queued_d[op_task]  = 1'b1;
          level_we           = 1'b1;
          total_d            = total_q + count_t'(1);
        end
      end
      ACT_REMOVE: begin
        if (!queued_q[op_task] || task_level_q[op_task] != op_i.level) begin
          status = ST_BAD_STATE;
        end else begin
          if (is_head && is_tail) begin
            bitmap_d[op_level] = 1'b0;
          end else begin
            if (is_head) begin
              head_we = 1'b1;
              head_wd = next_t;
            end else begin
              next_we = 1'b1;
              next_wa = prev_t;
              next_wd = next_t;
            end
            if (is_tail) begin
              tail_we = 1'b1;
              tail_wd = prev_t;
            end else begin
              prev_we = 1'b1;
              prev_wa = next_t;
              prev_wd = prev_t;
            end
          end
          queued_d[op_task] = 1'b0;
          total_d           = total_q - count_t'(1);
        end
      end
      ACT_ROTATE: begin
        if (!top_cur.found) begin
          status = ST_BAD_STATE;
        end else if (head_cur != tail_cur) begin
          // The old head moves behind the old tail; its successor leads.
          head_we = 1'b1;
          head_wd = next_t;
          next_we = 1'b1;
          prev_we = 1'b1;
          tail_we = 1'b1;
        end
      end
      default: begin
        status = ST_BAD_ARG;
      end
    endcase
  end

  // The result reflects the state after this action, including the head write.
  always_comb begin
    top_new  = first_set(bitmap_d);
    head_new = (head_we && top_new.idx == op_level) ? head_wd : head_q[top_new.idx];
    result_o.status           = status;
    result_o.highest_valid    = top_new.found;
    result_o.highest_task     = top_new.found ? head_new : '0;
    result_o.highest_priority = top_new.found ? top_new.idx : '0;
    result_o.ready_count      = total_d;
    result_o.ready_bitmap     = bitmap_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q <= '0;
      bitmap_q <= '0;
      total_q  <= '0;
    end else if (exec_i) begin
      queued_q <= queued_d;
      bitmap_q <= bitmap_d;
      total_q  <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_i) begin
      if (level_we) begin
        task_level_q[op_task] <= op_level;
      end
      if (head_we) begin
        head_q[op_level] <= head_wd;
      end
      if (tail_we) begin
        tail_q[op_level] <= tail_wd;
      end
      if (next_we) begin
        next_q[next_wa] <= next_wd;
      end
      if (prev_we) begin
        prev_q[prev_wa] <= prev_wd;
      end
    end
  end

  a_count_matches_queued: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    COUNT_W'($countones(queued_q)) == total_q
  ) else $error("ready count differs from number of queued tasks");

  a_bitmap_tracks_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (total_q == '0) == (bitmap_q == '0)
  ) else $error("level bitmap and ready count disagree on emptiness");

  a_insert_counts_up: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    exec_i && op_i.action == ACT_INSERT && status == ST_OK
    |=> total_q == $past(total_q) + count_t'(1)
  ) else $error("successful insert did not raise the ready count");

endmodule

@@ design/priority_ready_queue_scheduler.sv @@
// Channel | Direction | Handshake                | Beat contents
// in      | input     | in_valid_i / in_ready_o  | action_i, task_id_i, priority_req_i
// out     | output    | out_valid_o / out_ready_i| status_o, highest_*_o, ready_count_o,
//         |           |                          | ready_bitmap_o
//
// One input beat per cycle is sustained while the output is not stalled; each
// beat yields one output beat, valid once it has passed the input register
// and the ready-set update and the bitmap priority encoder have finished
// into the result register. Reset clears the queued flags, the level bitmap
// and the ready count; the link tables need no clearing pass.
// A stalled output holds its beat; the input register still takes one beat.
module priority_ready_queue_scheduler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  prq_pkg::task_t               task_id_i,
  input  prq_pkg::level_t              priority_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic                         highest_valid_o,
  output prq_pkg::task_t               highest_task_o,
  output prq_pkg::level_t              highest_priority_o,
  output prq_pkg::count_t              ready_count_o,
  output prq_pkg::bitmap_t             ready_bitmap_o
);
  import prq_pkg::*;

  logic    in_valid_q, out_valid_q, advance;
  op_t     op_q;
  result_t result, res_q;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  prq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .exec_i   (advance),
    .op_i     (op_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q.action  <= action_i;
      op_q.task_id <= task_id_i;
      op_q.level   <= priority_req_i;
    end
    if (advance) begin
      res_q <= result;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = res_q.status;
  assign highest_valid_o    = res_q.highest_valid;
  assign highest_task_o     = res_q.highest_task;
  assign highest_priority_o = res_q.highest_priority;
  assign ready_count_o      = res_q.ready_count;
  assign ready_bitmap_o     = res_q.ready_bitmap;

  a_advance_fills_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q
  ) else $error("processed beat did not reach the result register");

  a_highest_level_set: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.highest_valid |-> res_q.ready_bitmap[res_q.highest_priority]
  ) else $error("reported highest level is not set in the bitmap");

  a_highest_is_first: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.highest_valid == (res_q.ready_bitmap != '0))
  ) else $error("highest valid flag disagrees with the bitmap");

endmodule
